// ===== sv/tpts_pkg.sv =====
// Shared types and codes for the two-wire packet transaction sequencer.
// Holds opcodes, bus commands, mode codes, bus status codes and item structs.
// No dependencies.
package tpts_pkg;

  // Input item opcodes
  localparam logic [2:0] OP_BUS_EVENT = 3'd0;
  localparam logic [2:0] OP_LOAD_TX   = 3'd1;
  localparam logic [2:0] OP_MWR       = 3'd2;
  localparam logic [2:0] OP_MWR_RD    = 3'd3;
  localparam logic [2:0] OP_ARM_SRX   = 3'd4;
  localparam logic [2:0] OP_ARM_STX   = 3'd5;
  localparam logic [2:0] OP_POLL      = 3'd6;

  // Bus engine commands
  localparam logic [2:0] CMD_NONE       = 3'd0;
  localparam logic [2:0] CMD_GO_ACK     = 3'd1;
  localparam logic [2:0] CMD_GO_NOACK   = 3'd2;
  localparam logic [2:0] CMD_GO_IRQOFF  = 3'd3;
  localparam logic [2:0] CMD_STOP       = 3'd4;
  localparam logic [2:0] CMD_STOP_REARM = 3'd5;
  localparam logic [2:0] CMD_START      = 3'd6;
  localparam logic [2:0] CMD_CLEAR      = 3'd7;

  // Sequencer modes
  localparam logic [2:0] MODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_SRX  = 3'd1;
  localparam logic [2:0] MODE_STX  = 3'd2;
  localparam logic [2:0] MODE_MRD  = 3'd3;
  localparam logic [2:0] MODE_MWR  = 3'd4;

  // Bus engine status codes (low three bits masked)
  localparam logic [7:0] STATUS_MASK        = 8'hF8;
  localparam logic [7:0] ST_START           = 8'h08;
  localparam logic [7:0] ST_REP_START       = 8'h10;
  localparam logic [7:0] ST_MT_SLA_ACK      = 8'h18;
  localparam logic [7:0] ST_MT_SLA_NACK     = 8'h20;
  localparam logic [7:0] ST_MT_DATA_ACK     = 8'h28;
  localparam logic [7:0] ST_MT_DATA_NACK    = 8'h30;
  localparam logic [7:0] ST_ARB_LOST        = 8'h38;
  localparam logic [7:0] ST_MR_SLA_ACK      = 8'h40;
  localparam logic [7:0] ST_MR_SLA_NACK     = 8'h48;
  localparam logic [7:0] ST_MR_DATA_ACK     = 8'h50;
  localparam logic [7:0] ST_MR_DATA_NACK    = 8'h58;
  localparam logic [7:0] ST_SR_SLA_ACK      = 8'h60;
  localparam logic [7:0] ST_SR_ARB_LOST_SLA = 8'h68;
  localparam logic [7:0] ST_SR_DATA_ACK     = 8'h80;
  localparam logic [7:0] ST_SR_GEN_DATA_ACK = 8'h88;
  localparam logic [7:0] ST_SR_STOP         = 8'hA0;
  localparam logic [7:0] ST_ST_SLA_ACK      = 8'hA8;
  localparam logic [7:0] ST_ST_ARB_LOST_SLA = 8'hB0;
  localparam logic [7:0] ST_ST_DATA_ACK     = 8'hB8;
  localparam logic [7:0] ST_ST_DATA_NACK    = 8'hC0;

  // Data constants
  localparam logic [7:0] RX_HEADER_BYTE = 8'h06;
  localparam logic [7:0] TX_FILL_BYTE   = 8'hFF;
  localparam logic [7:0] RW_CLEAR_MASK  = 8'hFE;
  localparam logic [7:0] RW_SET_MASK    = 8'h01;

  // Status flag bits
  localparam logic [3:0] FLAG_OK    = 4'b0001;
  localparam logic [3:0] FLAG_RXBUF = 4'b0010;
  localparam logic [3:0] FLAG_ACK   = 4'b0100;
  localparam logic [3:0] FLAG_NACK  = 4'b1000;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] status_code;
    logic [7:0] received_byte;
    logic [3:0] buffer_index;
    logic [7:0] load_byte;
  } item_t;

  typedef struct packed {
    logic [2:0] bus_command;
    logic [7:0] drive_byte;
    logic       drive_valid;
    logic       busy_flag;
    logic [2:0] current_mode;
    logic       transfer_ok;
    logic [1:0] ack_outcome;
    logic       rx_in_buffer;
    logic [7:0] read_byte;
    logic [4:0] rx_count;
    logic       accepted;
  } result_t;

  typedef struct packed {
    logic       busy;
    logic [2:0] mode;
  } eng_status_t;

endpackage

// ===== sv/tpts_in_stage.sv =====
// Input register of the packet sequencer: captures one transaction from the slave side.
// Depends on tpts_pkg.
module tpts_in_stage
  import tpts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic [2:0]  s_tuser,
  input  logic        advance,
  output item_t       item,
  output logic        valid
);

  assign s_tready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.opcode        <= s_tuser;
      item.status_code   <= s_tdata[7:0];
      item.received_byte <= s_tdata[15:8];
      item.buffer_index  <= s_tdata[19:16];
      item.load_byte     <= s_tdata[27:20];
    end
  end

endmodule

// ===== sv/tpts_engine.sv =====
// Sequencer state and single-pass step logic: mode, flags, offsets, packet stores.
// Depends on tpts_pkg.
module tpts_engine
  import tpts_pkg::*;
#(
  parameter int PACKET_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  item_t       item,
  output result_t     result,
  output eng_status_t status
);

  localparam int AW = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
  localparam int CW = $clog2(PACKET_BYTES + 1);
  localparam int XW = (CW > 4) ? CW : 4;
  localparam logic [CW-1:0] PB_C = CW'(PACKET_BYTES);
  localparam logic [AW-1:0] ADDR0 = '0;

  logic [7:0]    tx_store [PACKET_BYTES];
  logic [7:0]    rx_store [PACKET_BYTES];
  logic [2:0]    mode;
  logic          busy;
  logic          len_set;
  logic [CW-1:0] pos;
  logic          idle;
  logic [CW-1:0] fill;
  logic [3:0]    flags;

  logic [2:0]    mode_next;
  logic          busy_next;
  logic          len_set_next;
  logic [CW-1:0] pos_next;
  logic          idle_next;
  logic [CW-1:0] fill_next;
  logic [3:0]    flags_next;

  logic          tx_we, rx_we;
  logic [AW-1:0] tx_wa, rx_wa;
  logic [7:0]    tx_wd, rx_wd;

  logic [2:0]    cmd;
  logic [7:0]    drv;
  logic          dv;
  logic          acc;

  logic [7:0]    st;
  logic          mr;
  logic          tx_avail;
  logic [7:0]    tx_cur;
  logic [7:0]    tx0_set;
  logic          master_blocked;
  logic          slave_blocked;
  logic [XW-1:0] idx_x;
  logic          idx_ok;
  logic          rx_room;
  logic [7:0]    rd_byte;

  always_comb begin
    st             = item.status_code & STATUS_MASK;
    mr             = (mode == MODE_MRD);
    tx_avail       = !idle && len_set && (pos < PB_C);
    tx_cur         = tx_store[pos[AW-1:0]];
    tx0_set        = tx_store[0] | RW_SET_MASK;
    master_blocked = busy || !idle;
    slave_blocked  = busy || (mode != MODE_IDLE);
    idx_x          = XW'(item.buffer_index);
    idx_ok         = idx_x < XW'(PACKET_BYTES);
    rx_room        = fill < PB_C;

    mode_next    = mode;
    busy_next    = busy;
    len_set_next = len_set;
    pos_next     = pos;
    idle_next    = idle;
    fill_next    = fill;
    flags_next   = flags;
    tx_we = 1'b0;  tx_wa = ADDR0;  tx_wd = 8'h00;
    rx_we = 1'b0;  rx_wa = ADDR0;  rx_wd = 8'h00;
    cmd = CMD_NONE;
    drv = 8'h00;
    dv  = 1'b0;
    acc = 1'b0;

    case (item.opcode)
      OP_BUS_EVENT: begin
        acc = 1'b1;
        case (mode)
          MODE_SRX: begin
            if (st == ST_SR_SLA_ACK) begin
              rx_we = 1'b1;  rx_wa = ADDR0;  rx_wd = RX_HEADER_BYTE;
              fill_next = CW'(1);
              cmd = CMD_GO_ACK;
              busy_next = 1'b1;
            end else if (st == ST_SR_DATA_ACK || st == ST_SR_GEN_DATA_ACK) begin
              if (rx_room) begin
                rx_we = 1'b1;  rx_wa = fill[AW-1:0];  rx_wd = item.received_byte;
                fill_next = fill + CW'(1);
              end
              cmd = CMD_GO_ACK;
            end else if (st == ST_SR_STOP) begin
              flags_next = (flags | FLAG_RXBUF) & ~FLAG_OK;
              if (fill == PB_C) flags_next = flags_next | FLAG_OK;
              cmd = CMD_GO_IRQOFF;
            end else begin
              flags_next = 4'b0000;
              cmd = CMD_STOP;
              mode_next = MODE_SRX;
              busy_next = 1'b0;
              fill_next = '0;
            end
          end
          MODE_STX: begin
            if (st == ST_ST_SLA_ACK || st == ST_ST_DATA_ACK || st == ST_ST_DATA_NACK) begin
              dv = 1'b1;
              if (tx_avail) begin
                drv = tx_cur;
                pos_next = pos + CW'(1);
              end else begin
                idle_next = 1'b1;
                drv = TX_FILL_BYTE;
              end
              cmd = CMD_GO_ACK;
            end else begin
              flags_next = 4'b0000;
              cmd = CMD_STOP;
              mode_next = MODE_SRX;
              busy_next = 1'b0;
              fill_next = '0;
              idle_next = 1'b1;
            end
          end
          MODE_MRD, MODE_MWR: begin
            if (st == ST_START) begin
              // Restart the packet from offset 0
              dv = 1'b1;
              idle_next = 1'b0;
              if (len_set) begin
                drv = tx_store[0];
                pos_next = CW'(1);
              end else begin
                pos_next = '0;
                idle_next = 1'b1;
                drv = TX_FILL_BYTE;
              end
              cmd = CMD_GO_ACK;
            end else if (st == ST_REP_START) begin
              // Set the R/W bit again for the read phase
              tx_we = 1'b1;  tx_wa = ADDR0;  tx_wd = tx0_set;
              rx_we = 1'b1;  rx_wa = ADDR0;  rx_wd = tx0_set;
              drv = tx0_set;
              dv = 1'b1;
              fill_next = mr ? CW'(1) : '0;
              cmd = CMD_GO_ACK;
              mode_next = MODE_MRD;
            end else if (st == ST_ARB_LOST) begin
              cmd = CMD_START;
              if (!mr) pos_next = '0;
            end else if (st == ST_MT_SLA_ACK || st == ST_MT_DATA_ACK) begin
              if (tx_avail) begin
                drv = tx_cur;
                dv = 1'b1;
                pos_next = pos + CW'(1);
                cmd = CMD_GO_ACK;
              end else begin
                idle_next = 1'b1;
                busy_next = 1'b0;
                mode_next = MODE_IDLE;
                if (mr) fill_next = '0;
                flags_next = FLAG_ACK;
                cmd = CMD_STOP;
              end
            end else if (st == ST_SR_ARB_LOST_SLA || st == ST_ST_ARB_LOST_SLA) begin
              mode_next = MODE_SRX;
              fill_next = CW'(1);
              rx_we = 1'b1;  rx_wa = ADDR0;  rx_wd = item.received_byte;
              cmd = CMD_GO_NOACK;
              flags_next = flags | FLAG_RXBUF;
            end else if (mr && st == ST_MR_SLA_ACK) begin
              rx_we = 1'b1;  rx_wa = ADDR0;  rx_wd = item.received_byte;
              fill_next = CW'(1);
              cmd = CMD_GO_ACK;
            end else if (mr && st == ST_MR_DATA_ACK) begin
              if (rx_room) begin
                rx_we = 1'b1;  rx_wa = fill[AW-1:0];  rx_wd = item.received_byte;
                fill_next = fill + CW'(1);
              end
              cmd = CMD_GO_ACK;
            end else begin
              // Not acknowledged flags a NACK; any other code aborts silently
              if (st == ST_MT_DATA_NACK || st == ST_MT_SLA_NACK ||
                  (mr && (st == ST_MR_SLA_NACK || st == ST_MR_DATA_NACK))) begin
                flags_next = FLAG_NACK;
              end else begin
                flags_next = 4'b0000;
              end
              cmd = CMD_STOP_REARM;
              mode_next = MODE_IDLE;
              busy_next = 1'b0;
              fill_next = '0;
              idle_next = 1'b1;
            end
          end
          default: begin
            cmd = CMD_CLEAR;
          end
        endcase
      end
      OP_LOAD_TX: begin
        if (!master_blocked && idx_ok) begin
          tx_we = 1'b1;  tx_wa = idx_x[AW-1:0];  tx_wd = item.load_byte;
          acc = 1'b1;
        end
      end
      OP_MWR, OP_MWR_RD: begin
        if (!master_blocked) begin
          if (item.opcode == OP_MWR_RD) begin
            tx_we = 1'b1;  tx_wa = ADDR0;  tx_wd = tx_store[0] & RW_CLEAR_MASK;
          end
          len_set_next = 1'b1;
          pos_next = '0;
          idle_next = 1'b0;
          busy_next = 1'b1;
          cmd = CMD_START;
          mode_next = (item.opcode == OP_MWR_RD) ? MODE_MRD : MODE_MWR;
          acc = 1'b1;
        end
      end
      OP_ARM_SRX: begin
        if (!slave_blocked) begin
          flags_next = 4'b0000;
          cmd = CMD_GO_ACK;
          mode_next = MODE_SRX;
          busy_next = 1'b0;
          fill_next = '0;
          acc = 1'b1;
        end
      end
      OP_ARM_STX: begin
        if (!slave_blocked) begin
          len_set_next = 1'b1;
          pos_next = '0;
          idle_next = 1'b0;
          flags_next = 4'b0000;
          cmd = CMD_GO_ACK;
          mode_next = MODE_STX;
          acc = 1'b1;
        end
      end
      OP_POLL: begin
        if (busy && flags[0]) begin
          fill_next = '0;
          mode_next = MODE_IDLE;
          busy_next = 1'b0;
          acc = 1'b1;
        end
      end
      default: begin
        acc = 1'b0;
      end
    endcase

    // Forward this step's receive write to the read port
    if (!idx_ok) begin
      rd_byte = 8'h00;
    end else if (rx_we && rx_wa == idx_x[AW-1:0]) begin
      rd_byte = rx_wd;
    end else begin
      rd_byte = rx_store[idx_x[AW-1:0]];
    end

    result.bus_command  = cmd;
    result.drive_byte   = drv;
    result.drive_valid  = dv;
    result.busy_flag    = busy_next;
    result.current_mode = mode_next;
    result.transfer_ok  = flags_next[0];
    result.ack_outcome  = flags_next[3:2];
    result.rx_in_buffer = flags_next[1];
    result.read_byte    = rd_byte;
    result.rx_count     = 5'(fill_next);
    result.accepted     = acc;
  end

  assign status.busy = busy;
  assign status.mode = mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_IDLE;
      busy    <= 1'b0;
      len_set <= 1'b0;
      pos     <= '0;
      idle    <= 1'b1;
      fill    <= '0;
      flags   <= 4'b0000;
      for (int i = 0; i < PACKET_BYTES; i++) begin
        tx_store[i] <= 8'h00;
        rx_store[i] <= 8'h00;
      end
    end else if (step) begin
      mode    <= mode_next;
      busy    <= busy_next;
      len_set <= len_set_next;
      pos     <= pos_next;
      idle    <= idle_next;
      fill    <= fill_next;
      flags   <= flags_next;
      if (tx_we) tx_store[tx_wa] <= tx_wd;
      if (rx_we) rx_store[rx_wa] <= rx_wd;
    end
  end

endmodule

// ===== sv/tpts_out_stage.sv =====
// Result register of the packet sequencer: holds one result transaction for the master side.
// Depends on tpts_pkg.
module tpts_out_stage
  import tpts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  result_t     result,
  output logic        free,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata
);

  result_t held;

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (free) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign m_tdata = {6'b000000, held.accepted, held.rx_count, held.read_byte,
                    held.rx_in_buffer, held.ack_outcome, held.transfer_ok,
                    held.current_mode, held.busy_flag, held.drive_valid,
                    held.drive_byte, held.bus_command};

endmodule

// ===== sv/twi_packet_transaction_sequencer_core.sv =====
// Two-wire packet transaction sequencer, top level.
// An accepted transaction is held in the input register, then its result in the result register.
// One transaction per cycle unless m_tready stalls; the whole step runs between the two registers.
// Reset (rst, synchronous, active high): mode idle, not busy, no transmit pending, flags and
// fill count zero, both packet stores cleared, both pipeline registers empty.
// Depends on tpts_pkg, tpts_in_stage, tpts_engine, tpts_out_stage.
module twi_packet_transaction_sequencer_core
  import tpts_pkg::*;
#(
  parameter int PACKET_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [7:0] status_code, [15:8] received_byte, [19:16] buffer_index, [27:20] load_byte
  input  logic [31:0] s_tdata,
  // [2:0] opcode
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [2:0] bus_command, [10:3] drive_byte, [11] drive_valid, [12] busy_flag,
  // [15:13] current_mode, [16] transfer_ok, [18:17] ack_outcome, [19] rx_in_buffer,
  // [27:20] read_byte, [32:28] rx_count, [33] accepted
  output logic [39:0] m_tdata
);

  item_t       item;
  logic        item_valid;
  logic        out_free;
  logic        advance;
  result_t     result;
  eng_status_t eng_status;

  // Step the engine whenever a held item can move into a free result register
  assign advance = item_valid && out_free;

  tpts_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .advance  (advance),
    .item     (item),
    .valid    (item_valid)
  );

  // All state updates and the result are computed here in one pass
  tpts_engine #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (item),
    .result (result),
    .status (eng_status)
  );

  tpts_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .result   (result),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // A transfer in progress always belongs to some active mode
  a_busy_has_mode: assert property (@(posedge clk) disable iff (rst)
    eng_status.busy |-> eng_status.mode != MODE_IDLE)
    else $error("busy while idle");

  // Every bus event is reported as accepted
  a_event_accepted: assert property (@(posedge clk) disable iff (rst)
    advance && item.opcode == OP_BUS_EVENT |=> m_tdata[33])
    else $error("bus event not accepted");

  // No byte is driven without its qualifier
  a_drive_zero: assert property (@(posedge clk) disable iff (rst)
    advance && !result.drive_valid |-> result.drive_byte == 8'h00)
    else $error("drive byte without drive valid");

  // Refused command leaves the bus alone
  a_refused_quiet: assert property (@(posedge clk) disable iff (rst)
    advance && !result.accepted |-> result.bus_command == CMD_NONE)
    else $error("command issued for refused transaction");

endmodule
